/* hw/rtl/tlrr_pkg.sv */
// Shared types and codes for the two-level round-robin / FCFS scheduler.
package tlrr_pkg;

    localparam logic [1:0] FN_LOAD  = 2'd0;
    localparam logic [1:0] FN_START = 2'd1;
    localparam logic [1:0] FN_TICK  = 2'd2;

    typedef enum logic [2:0] {
        EV_ACCEPTED   = 3'd0,
        EV_REJECTED   = 3'd1,
        EV_SCHEDULED  = 3'd2,
        EV_RESUMED    = 3'd3,
        EV_TERMINATED = 3'd4,
        EV_SUSPENDED  = 3'd5,
        EV_FINISHED   = 3'd6,
        EV_IDLE       = 3'd7
    } event_t;

    typedef struct packed {
        logic [15:0] id;
        logic [15:0] burst;
    } job_entry_t;

    typedef struct packed {
        logic       push;
        logic       pop;
        job_entry_t data;
    } fifo_req_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

/* hw/rtl/tlrr_fifo.sv */
// Job FIFO: synchronous memory with head, tail and fill count; registered read.
module tlrr_fifo #(
    parameter int DEPTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tlrr_pkg::fifo_req_t  req,
    output tlrr_pkg::job_entry_t rd_data,
    output tlrr_pkg::fifo_stat_t stat
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    tlrr_pkg::job_entry_t mem [DEPTH];

    logic [ADDR_W-1:0] head_reg, head_next;
    logic [ADDR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    tlrr_pkg::job_entry_t rd_reg;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (req.push)
        begin
            tail_next  = (tail_reg == ADDR_W'(DEPTH - 1)) ? '0 : tail_reg + ADDR_W'(1);
            count_next = count_next + CNT_W'(1);
        end
        if (req.pop)
        begin
            head_next  = (head_reg == ADDR_W'(DEPTH - 1)) ? '0 : head_reg + ADDR_W'(1);
            count_next = count_next - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.push)
        begin
            mem[tail_reg] <= req.data;
        end
        if (req.pop)
        begin
            rd_reg <= mem[head_reg];
        end
    end

    assign rd_data    = rd_reg;
    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

/* hw/rtl/tlrr_core.sv */
// Scheduler sequencer: running job, time counter, dispatch and result register.
module tlrr_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [15:0]          slice_cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           func,
    input  logic [15:0]          job_id,
    input  logic [15:0]          burst_ticks,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [2:0]           event_res,
    output logic [15:0]          job_id_out,
    output logic [15:0]          granted_ticks,
    output logic [31:0]          elapsed_ticks,
    output logic                 last,
    output tlrr_pkg::fifo_req_t  first_req,
    input  tlrr_pkg::fifo_stat_t first_stat,
    input  tlrr_pkg::job_entry_t first_rd,
    output tlrr_pkg::fifo_req_t  second_req,
    input  tlrr_pkg::fifo_stat_t second_stat,
    input  tlrr_pkg::job_entry_t second_rd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DSEL,
        S_DISP
    } state_t;

    state_t state_reg, state_next;
    logic [1:0]  func_reg, func_next;
    logic [15:0] id_reg, id_next;
    logic [15:0] burst_reg, burst_next;
    logic        run_valid_reg, run_valid_next;
    logic [15:0] run_id_reg, run_id_next;
    logic [15:0] run_left_reg, run_left_next;
    logic [15:0] slice_left_reg, slice_left_next;
    logic [31:0] tick_reg, tick_next;
    logic        sel_second_reg, sel_second_next;
    logic        out_valid_reg, out_valid_next;
    tlrr_pkg::event_t ev_reg, ev_next;
    logic [15:0] oid_reg, oid_next;
    logic [15:0] grant_reg, grant_next;
    logic [31:0] time_reg, time_next;
    logic        last_reg, last_next;

    logic        slot_free;
    logic        emit;
    logic [31:0] tick_inc;
    logic [15:0] slice_dec;
    logic [15:0] slice_eff;
    logic [15:0] sched_grant;
    tlrr_pkg::job_entry_t disp_entry;

    assign slot_free  = !out_valid_reg || out_ready;
    assign tick_inc   = (tick_reg == '1) ? tick_reg : tick_reg + 32'd1;
    assign slice_dec  = (slice_left_reg == '0) ? '0 : slice_left_reg - 16'd1;
    assign slice_eff  = (slice_cfg == '0) ? 16'd1 : slice_cfg;
    assign disp_entry = sel_second_reg ? second_rd : first_rd;
    assign sched_grant = (disp_entry.burst < slice_eff) ? disp_entry.burst : slice_eff;

    always_comb
    begin
        state_next      = state_reg;
        func_next       = func_reg;
        id_next         = id_reg;
        burst_next      = burst_reg;
        run_valid_next  = run_valid_reg;
        run_id_next     = run_id_reg;
        run_left_next   = run_left_reg;
        slice_left_next = slice_left_reg;
        tick_next       = tick_reg;
        sel_second_next = sel_second_reg;
        emit            = 1'b0;
        ev_next         = ev_reg;
        oid_next        = oid_reg;
        grant_next      = grant_reg;
        time_next       = tick_reg;
        last_next       = 1'b1;
        first_req       = '0;
        second_req      = '0;
        first_req.data  = '{id: id_reg, burst: burst_reg};
        second_req.data = '{id: run_id_reg, burst: run_left_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next  = func;
                    id_next    = job_id;
                    burst_next = burst_ticks;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                    unique case (func_reg)
                        tlrr_pkg::FN_LOAD:
                        begin
                            emit     = 1'b1;
                            oid_next = id_reg;
                            grant_next = '0;
                            if (burst_reg == '0 || first_stat.full)
                            begin
                                ev_next = tlrr_pkg::EV_REJECTED;
                            end
                            else
                            begin
                                first_req.push = 1'b1;
                                ev_next = tlrr_pkg::EV_ACCEPTED;
                            end
                        end
                        tlrr_pkg::FN_START:
                        begin
                            if (run_valid_reg)
                            begin
                                emit       = 1'b1;
                                ev_next    = tlrr_pkg::EV_IDLE;
                                oid_next   = '0;
                                grant_next = '0;
                            end
                            else
                            begin
                                state_next = S_DSEL;
                            end
                        end
                        tlrr_pkg::FN_TICK:
                        begin
                            emit       = 1'b1;
                            grant_next = '0;
                            if (!run_valid_reg)
                            begin
                                ev_next  = tlrr_pkg::EV_IDLE;
                                oid_next = '0;
                            end
                            else
                            begin
                                tick_next       = tick_inc;
                                time_next       = tick_inc;
                                slice_left_next = slice_dec;
                                oid_next        = run_id_reg;
                                priority if (slice_dec != '0)
                                begin
                                    ev_next = tlrr_pkg::EV_IDLE;
                                end
                                else if (run_left_reg == '0)
                                begin
                                    ev_next    = tlrr_pkg::EV_TERMINATED;
                                    last_next  = 1'b0;
                                    state_next = S_DSEL;
                                end
                                else if (second_stat.full)
                                begin
                                    // no room to park it: keep it running on its full remainder
                                    ev_next         = tlrr_pkg::EV_RESUMED;
                                    grant_next      = run_left_reg;
                                    slice_left_next = run_left_reg;
                                    run_left_next   = '0;
                                end
                                else
                                begin
                                    second_req.push = 1'b1;
                                    ev_next    = tlrr_pkg::EV_SUSPENDED;
                                    last_next  = 1'b0;
                                    state_next = S_DSEL;
                                end
                            end
                        end
                        default:
                        begin
                            emit       = 1'b1;
                            ev_next    = tlrr_pkg::EV_IDLE;
                            oid_next   = '0;
                            grant_next = '0;
                        end
                    endcase
                end
            end
            S_DSEL:
            begin
                // pushes from the previous cycle are already in memory and counts
                priority if (!first_stat.empty)
                begin
                    first_req.pop   = 1'b1;
                    sel_second_next = 1'b0;
                    state_next      = S_DISP;
                end
                else if (!second_stat.empty)
                begin
                    second_req.pop  = 1'b1;
                    sel_second_next = 1'b1;
                    state_next      = S_DISP;
                end
                else
                begin
                    if (slot_free)
                    begin
                        emit            = 1'b1;
                        ev_next         = tlrr_pkg::EV_FINISHED;
                        oid_next        = '0;
                        grant_next      = '0;
                        run_valid_next  = 1'b0;
                        run_id_next     = '0;
                        run_left_next   = '0;
                        slice_left_next = '0;
                        state_next      = S_IDLE;
                    end
                end
            end
            S_DISP:
            begin
                if (slot_free)
                begin
                    emit           = 1'b1;
                    run_valid_next = 1'b1;
                    run_id_next    = disp_entry.id;
                    oid_next       = disp_entry.id;
                    if (sel_second_reg)
                    begin
                        ev_next         = tlrr_pkg::EV_RESUMED;
                        slice_left_next = disp_entry.burst;
                        run_left_next   = '0;
                        grant_next      = disp_entry.burst;
                    end
                    else
                    begin
                        ev_next         = tlrr_pkg::EV_SCHEDULED;
                        slice_left_next = sched_grant;
                        run_left_next   = disp_entry.burst - sched_grant;
                        grant_next      = sched_grant;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = emit || (out_valid_reg && !out_ready);
        if (!emit)
        begin
            ev_next    = ev_reg;
            oid_next   = oid_reg;
            grant_next = grant_reg;
            time_next  = time_reg;
            last_next  = last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            run_valid_reg  <= 1'b0;
            run_id_reg     <= '0;
            run_left_reg   <= '0;
            slice_left_reg <= '0;
            tick_reg       <= '0;
            out_valid_reg  <= 1'b0;
            sel_second_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            run_valid_reg  <= run_valid_next;
            run_id_reg     <= run_id_next;
            run_left_reg   <= run_left_next;
            slice_left_reg <= slice_left_next;
            tick_reg       <= tick_next;
            out_valid_reg  <= out_valid_next;
            sel_second_reg <= sel_second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg  <= func_next;
        id_reg    <= id_next;
        burst_reg <= burst_next;
        ev_reg    <= ev_next;
        oid_reg   <= oid_next;
        grant_reg <= grant_next;
        time_reg  <= time_next;
        last_reg  <= last_next;
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign event_res     = ev_reg;
    assign job_id_out    = oid_reg;
    assign granted_ticks = grant_reg;
    assign elapsed_ticks = time_reg;
    assign last          = last_reg;

endmodule

/* hw/rtl/two_level_rr_fcfs_scheduler.sv */
// Top level of the two-level scheduler: slice register, two job FIFOs, sequencer.
//
//  channel | direction | handshake            | beat contents
//  in      | in        | in_valid / in_ready  | func, job_id, burst_ticks
//  out     | out       | out_valid / out_ready| event_res, job_id_out, granted_ticks,
//          |           |                      | elapsed_ticks, last
//  cfg     | in        | cfg_valid / cfg_ready| cfg_data (slice_length)
//
// Sequence: a load, a tick without dispatch, or an idle result passes S_IDLE and S_EXEC;
// a dispatch adds S_DSEL for selection and S_DISP for the FIFO memory read.
// The registered read of the job memories is why a dispatch needs the S_DISP state.
// Reset: asynchronous, active low; FIFOs empty at once, no clearing pass.
// Stalls: out_ready low holds the result register; the sequencer waits on it before
// emitting the next beat, and in_ready stays low until the item's last beat is issued.
module two_level_rr_fcfs_scheduler #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [15:0] job_id,
    input  logic [15:0] burst_ticks,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  event_res,
    output logic [15:0] job_id_out,
    output logic [15:0] granted_ticks,
    output logic [31:0] elapsed_ticks,
    output logic        last
);

    logic [15:0] slice_reg;

    tlrr_pkg::fifo_req_t  first_req, second_req;
    tlrr_pkg::fifo_stat_t first_stat, second_stat;
    tlrr_pkg::job_entry_t first_rd, second_rd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slice_reg <= 16'd2;
        end
        else if (cfg_valid)
        begin
            slice_reg <= cfg_data;
        end
    end

    tlrr_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_first (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (first_req),
        .rd_data (first_rd),
        .stat    (first_stat)
    );

    tlrr_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_second (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (second_req),
        .rd_data (second_rd),
        .stat    (second_stat)
    );

    tlrr_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .slice_cfg     (slice_reg),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .job_id        (job_id),
        .burst_ticks   (burst_ticks),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .event_res     (event_res),
        .job_id_out    (job_id_out),
        .granted_ticks (granted_ticks),
        .elapsed_ticks (elapsed_ticks),
        .last          (last),
        .first_req     (first_req),
        .first_stat    (first_stat),
        .first_rd      (first_rd),
        .second_req    (second_req),
        .second_stat   (second_stat),
        .second_rd     (second_rd)
    );

endmodule

/* hw/rtl/tlrr_checker.sv */
// Port-level checks for the scheduler, bound to the top level.
module tlrr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  event_res,
    input logic [15:0] job_id_out,
    input logic [15:0] granted_ticks,
    input logic [31:0] elapsed_ticks,
    input logic        last
);

    // one item at a time: drop ready after taking a beat
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while an item is in progress");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_res)
            && $stable(job_id_out) && $stable(granted_ticks)
            && $stable(elapsed_ticks) && $stable(last))
        else $error("result beat changed while stalled");

    a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res != tlrr_pkg::EV_SCHEDULED
            && event_res != tlrr_pkg::EV_RESUMED |-> granted_ticks == '0)
        else $error("grant on a non-dispatch event");

    a_grant_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res == tlrr_pkg::EV_SCHEDULED
            || event_res == tlrr_pkg::EV_RESUMED) |-> granted_ticks != '0)
        else $error("dispatch with an empty grant");

    a_finished: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res == tlrr_pkg::EV_FINISHED |-> job_id_out == '0 && last)
        else $error("finished beat carries a job or is not final");

endmodule

bind two_level_rr_fcfs_scheduler tlrr_checker u_tlrr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .event_res     (event_res),
    .job_id_out    (job_id_out),
    .granted_ticks (granted_ticks),
    .elapsed_ticks (elapsed_ticks),
    .last          (last)
);

/* verif/tb_two_level_rr_fcfs_scheduler.sv */
// Self-checking testbench for the two-level round-robin / FCFS job scheduler.
module tb_two_level_rr_fcfs_scheduler;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         QDEPTH   = 16;
    localparam logic [1:0] FN_SPARE = 2'd3;

    typedef struct packed {
        tlrr_pkg::event_t ev;
        logic [15:0]      id;
        logic [15:0]      grant;
        logic [31:0]      at;
        logic             fin;
    } sched_event_t;

    // Scheduler predictor plus the queue of events still owed by the block
    class event_scoreboard;
        int unsigned          depth;
        logic [15:0]          slice_len;
        tlrr_pkg::job_entry_t ready_jobs[$];
        tlrr_pkg::job_entry_t parked_jobs[$];
        logic [15:0]          run_id;
        logic [15:0]          run_left;
        logic [15:0]          slice_left;
        logic [31:0]          ticks;
        bit                   running;
        sched_event_t         pending_events[$];
        int                   mismatches;
        int                   items_seen;
        int                   events_checked;
        int                   rejects;
        int                   inplace_resumes;
        int                   finishes;

        function new(int unsigned d);
            depth           = d;
            slice_len       = 16'd2;
            run_id          = '0;
            run_left        = '0;
            slice_left      = '0;
            ticks           = '0;
            running         = 1'b0;
            mismatches      = 0;
            items_seen      = 0;
            events_checked  = 0;
            rejects         = 0;
            inplace_resumes = 0;
            finishes        = 0;
        endfunction

        function void queue_event(tlrr_pkg::event_t ev, logic [15:0] id,
                                  logic [15:0] grant);
            pending_events.push_back('{ev, id, grant, ticks, 1'b0});
        endfunction

        function void dispatch_next();
            tlrr_pkg::job_entry_t e;
            logic [15:0]          sl;
            if (ready_jobs.size() != 0)
            begin
                e          = ready_jobs.pop_front();
                sl         = (slice_len == 16'd0) ? 16'd1 : slice_len;
                run_id     = e.id;
                slice_left = (e.burst < sl) ? e.burst : sl;
                run_left   = e.burst - slice_left;
                running    = 1'b1;
                queue_event(tlrr_pkg::EV_SCHEDULED, run_id, slice_left);
            end
            else if (parked_jobs.size() != 0)
            begin
                e          = parked_jobs.pop_front();
                run_id     = e.id;
                slice_left = e.burst;
                run_left   = '0;
                running    = 1'b1;
                queue_event(tlrr_pkg::EV_RESUMED, run_id, slice_left);
            end
            else
            begin
                running    = 1'b0;
                run_id     = '0;
                run_left   = '0;
                slice_left = '0;
                finishes++;
                queue_event(tlrr_pkg::EV_FINISHED, 16'd0, 16'd0);
            end
        endfunction

        function void note_item(logic [1:0] f, logic [15:0] jid, logic [15:0] jburst);
            tlrr_pkg::job_entry_t e;
            items_seen++;
            case (f)
                tlrr_pkg::FN_LOAD:
                begin
                    if (jburst == 16'd0 || ready_jobs.size() >= depth)
                    begin
                        rejects++;
                        queue_event(tlrr_pkg::EV_REJECTED, jid, 16'd0);
                    end
                    else
                    begin
                        e.id    = jid;
                        e.burst = jburst;
                        ready_jobs.push_back(e);
                        queue_event(tlrr_pkg::EV_ACCEPTED, jid, 16'd0);
                    end
                end
                tlrr_pkg::FN_START:
                begin
                    if (running)
                        queue_event(tlrr_pkg::EV_IDLE, 16'd0, 16'd0);
                    else
                        dispatch_next();
                end
                tlrr_pkg::FN_TICK:
                begin
                    if (!running)
                    begin
                        queue_event(tlrr_pkg::EV_IDLE, 16'd0, 16'd0);
                    end
                    else
                    begin
                        if (ticks != '1)
                            ticks++;
                        if (slice_left != 16'd0)
                            slice_left--;
                        if (slice_left != 16'd0)
                        begin
                            queue_event(tlrr_pkg::EV_IDLE, run_id, 16'd0);
                        end
                        else if (run_left == 16'd0)
                        begin
                            queue_event(tlrr_pkg::EV_TERMINATED, run_id, 16'd0);
                            dispatch_next();
                        end
                        else if (parked_jobs.size() >= depth)
                        begin
                            // no room to park: keep the job and grant the rest of its burst
                            slice_left = run_left;
                            run_left   = '0;
                            inplace_resumes++;
                            queue_event(tlrr_pkg::EV_RESUMED, run_id, slice_left);
                        end
                        else
                        begin
                            e.id    = run_id;
                            e.burst = run_left;
                            parked_jobs.push_back(e);
                            queue_event(tlrr_pkg::EV_SUSPENDED, run_id, 16'd0);
                            dispatch_next();
                        end
                    end
                end
                default: queue_event(tlrr_pkg::EV_IDLE, 16'd0, 16'd0);
            endcase
            pending_events[pending_events.size() - 1].fin = 1'b1;
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 200)
                    $display("%t: %s expected %0h got %0h", $time, name, want, got);
            end
        endfunction

        function void check_event(logic [2:0] ev, logic [15:0] id, logic [15:0] grant,
                                  logic [31:0] at, logic fin);
            sched_event_t w;
            if (pending_events.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 200)
                    $display("%t: result beat with none expected: event %0h id %0h",
                             $time, ev, id);
                return;
            end
            w = pending_events.pop_front();
            events_checked++;
            compare_field("event_res", 32'(w.ev), 32'(ev));
            compare_field("job_id_out", 32'(w.id), 32'(id));
            compare_field("granted_ticks", 32'(w.grant), 32'(grant));
            compare_field("elapsed_ticks", w.at, at);
            compare_field("last", 32'(w.fin), 32'(fin));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  func;
    logic [15:0] job_id;
    logic [15:0] burst_ticks;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  event_res;
    logic [15:0] job_id_out;
    logic [15:0] granted_ticks;
    logic [31:0] elapsed_ticks;
    logic        last;

    int snd_idle_pct = 14;
    int rcv_idle_pct = 55;

    event_scoreboard sb = new(QDEPTH);

    two_level_rr_fcfs_scheduler #(
        .QUEUE_DEPTH (QDEPTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .job_id        (job_id),
        .burst_ticks   (burst_ticks),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .event_res     (event_res),
        .job_id_out    (job_id_out),
        .granted_ticks (granted_ticks),
        .elapsed_ticks (elapsed_ticks),
        .last          (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_event(event_res, job_id_out, granted_ticks, elapsed_ticks, last);
    end

    // Offer one item, sometimes after a random gap, and hold it until the beat is taken
    task automatic send_item(input logic [1:0] f, input logic [15:0] jid,
                             input logic [15:0] jburst);
        @(negedge clk);
        if ($urandom_range(0, 99) < snd_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(negedge clk); while ($urandom_range(0, 99) < snd_idle_pct);
        end
        in_valid    <= 1'b1;
        func        <= f;
        job_id      <= jid;
        burst_ticks <= jburst;
        do @(posedge clk); while (!in_ready);
        sb.note_item(f, jid, jburst);
    endtask

    task automatic drop_valid();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending_events.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_slice(input logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        sb.slice_len = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_directed();
        send_item(FN_SPARE, 16'hFFFF, 16'hFFFF);
        send_item(tlrr_pkg::FN_TICK, 16'd0, 16'd0);
        send_item(tlrr_pkg::FN_START, 16'd0, 16'd0);
        send_item(tlrr_pkg::FN_LOAD, 16'h1234, 16'd0);
        // fill the first queue; ids walk from all-zero to all-one
        for (int k = 0; k < QDEPTH; k++)
            send_item(tlrr_pkg::FN_LOAD, 16'(k * 16'h1111),
                      (k == 0) ? 16'd1 : 16'((k % 4) + 2));
        send_item(tlrr_pkg::FN_LOAD, 16'h5A5A, 16'hFFFF);
        send_item(tlrr_pkg::FN_START, 16'd0, 16'd0);
        send_item(tlrr_pkg::FN_START, 16'd0, 16'd0);
        send_item(tlrr_pkg::FN_TICK, 16'd0, 16'd0);
        send_item(tlrr_pkg::FN_TICK, 16'd0, 16'd0);
        send_item(tlrr_pkg::FN_TICK, 16'd0, 16'd0);
    endtask

    task automatic run_chunk(input logic [15:0] slice_val, input int max_burst,
                             input int load_pct, input int n);
        int          done;
        int          r;
        logic [1:0]  f;
        logic [15:0] jid;
        logic [15:0] jb;
        done = 0;
        drop_valid();
        wait_drained();
        write_slice(slice_val);
        while (done < n)
        begin
            r   = $urandom_range(0, 99);
            jid = 16'($urandom);
            jb  = 16'($urandom);
            if (r < 3)
            begin
                f = FN_SPARE;
            end
            else if (r < 3 + load_pct)
            begin
                f = tlrr_pkg::FN_LOAD;
                // keep bursts short unless the load is bound to bounce off a full queue
                if (sb.ready_jobs.size() < sb.depth)
                begin
                    if ($urandom_range(0, 19) == 0)
                        jb = 16'd0;
                    else
                        jb = 16'($urandom_range(1, max_burst));
                end
            end
            else if (!sb.running)
            begin
                f = ($urandom_range(0, 9) == 0) ? tlrr_pkg::FN_TICK : tlrr_pkg::FN_START;
            end
            else
            begin
                f = ($urandom_range(0, 19) == 0) ? tlrr_pkg::FN_START : tlrr_pkg::FN_TICK;
            end
            send_item(f, jid, jb);
            if (f != FN_SPARE)
                done++;
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        func        = tlrr_pkg::FN_LOAD;
        job_id      = '0;
        burst_ticks = '0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        snd_idle_pct = 14;
        rcv_idle_pct = 55;
        run_directed();
        run_chunk(16'd1, 4, 50, 320);
        run_chunk(16'd3, 8, 30, 320);

        snd_idle_pct = 55;
        rcv_idle_pct = 14;
        run_chunk(16'hFFFF, 6, 35, 320);
        run_chunk(16'd0, 4, 45, 320);

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        run_chunk(16'd2, 6, 40, 310);
        run_chunk(16'($urandom_range(1, 7)), 10, 25, 310);

        drop_valid();
        wait_drained();

        $display("Covered %0d items and %0d result beats across six slice settings",
                 sb.items_seen, sb.events_checked);
        $display("Saw %0d rejected loads, %0d in-place resumes, %0d finished reports",
                 sb.rejects, sb.inplace_resumes, sb.finishes);
        if (sb.mismatches == 0 && sb.pending_events.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Mismatches found");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/tlrr_pkg.sv
hw/rtl/tlrr_fifo.sv
hw/rtl/tlrr_core.sv
hw/rtl/two_level_rr_fcfs_scheduler.sv
hw/rtl/tlrr_checker.sv
verif/tb_two_level_rr_fcfs_scheduler.sv
